// File: sv/prr7_pkg.sv
// ----------------------------------------------------------------------------
// prr7_pkg
// Shared types, constants and helper functions for the seven-element
// permutation rank/unrank pipeline.
// ----------------------------------------------------------------------------
package prr7_pkg;

    localparam int NUM_ELEMS = 7;
    localparam int NUM_PERMS = 5040;

    // Operation codes
    localparam logic OP_RANK   = 1'b0;
    localparam logic OP_UNRANK = 1'b1;

    typedef logic [2:0]  elem_t;
    typedef logic [12:0] rank_t;
    typedef logic [6:0]  mask_t;

    // Factorials 0! .. 6!
    localparam rank_t FACT [NUM_ELEMS] = '{13'd1, 13'd1, 13'd2, 13'd6, 13'd24, 13'd120, 13'd720};

    // Incoming request, as taken from the input ports
    typedef struct packed {
        logic            op;
        elem_t [6:0]     elem;
        rank_t           rank;
    } req_t;

    // Work item carried through the pipeline
    typedef struct packed {
        logic            op;
        logic            bad;
        elem_t [6:0]     digit;
        rank_t           rem;
        rank_t           acc;
        mask_t           used;
        elem_t [6:0]     pick;
    } work_t;

    // Final result
    typedef struct packed {
        rank_t           rank;
        elem_t [6:0]     elem;
        logic            bad;
    } res_t;

    // Quotient digit of r by a constant factorial f, for r below 7*f
    function automatic elem_t div_digit(input rank_t r, input rank_t f);
        elem_t d;
        d = '0;
        for (int k = 1; k < NUM_ELEMS; k++) begin
            if (r >= rank_t'(k * f)) begin
                d = d + elem_t'(1);
            end
        end
        return d;
    endfunction

    // Returns the d-th (from 0) value not set in used
    function automatic elem_t pick_nth(input mask_t used, input elem_t d);
        elem_t seen;
        elem_t pick;
        logic  found;
        seen  = '0;
        pick  = '0;
        found = 1'b0;
        for (int v = 0; v < NUM_ELEMS; v++) begin
            if (!used[v] && !found) begin
                if (seen == d) begin
                    pick  = elem_t'(v);
                    found = 1'b1;
                end else begin
                    seen = seen + elem_t'(1);
                end
            end
        end
        return pick;
    endfunction

    // Marks value v as used
    function automatic mask_t mark_used(input mask_t used, input elem_t v);
        return used | (mask_t'(1) << v);
    endfunction

endpackage

// File: sv/permutation_rank_unrank_7.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank_7
// Each conversion passes the registered stages decode, digits, merge and finish in order.
// Throughput: one conversion per cycle while no stall is held; each stage advances
// when empty or when the next stage takes its item, so a stall backs up without loss.
// Reset: rst_n clears the stage valid bits only; the payload registers are not reset.
// ----------------------------------------------------------------------------
module permutation_rank_unrank_7 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  prr7_pkg::elem_t      elem_in_0,
    input  prr7_pkg::elem_t      elem_in_1,
    input  prr7_pkg::elem_t      elem_in_2,
    input  prr7_pkg::elem_t      elem_in_3,
    input  prr7_pkg::elem_t      elem_in_4,
    input  prr7_pkg::elem_t      elem_in_5,
    input  prr7_pkg::elem_t      elem_in_6,
    input  prr7_pkg::rank_t      rank_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output prr7_pkg::rank_t      rank_out,
    output prr7_pkg::elem_t      elem_out_0,
    output prr7_pkg::elem_t      elem_out_1,
    output prr7_pkg::elem_t      elem_out_2,
    output prr7_pkg::elem_t      elem_out_3,
    output prr7_pkg::elem_t      elem_out_4,
    output prr7_pkg::elem_t      elem_out_5,
    output prr7_pkg::elem_t      elem_out_6,
    output logic                 bad_input
);
    import prr7_pkg::*;

    req_t  req;
    work_t s1_data;
    work_t s2_data;
    work_t s3_data;
    res_t  res;
    logic  s1_valid;
    logic  s2_valid;
    logic  s3_valid;
    logic  s1_ready;
    logic  s2_ready;
    logic  s3_ready;
    logic  s4_ready;

    // Pack the request
    assign req.op      = op;
    assign req.elem[0] = elem_in_0;
    assign req.elem[1] = elem_in_1;
    assign req.elem[2] = elem_in_2;
    assign req.elem[3] = elem_in_3;
    assign req.elem[4] = elem_in_4;
    assign req.elem[5] = elem_in_5;
    assign req.elem[6] = elem_in_6;
    assign req.rank    = rank_in;

    assign in_stall = !s1_ready;

    // Pipeline stages
    prr7_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (req),
        .up_ready   (s1_ready),
        .out_valid  (s1_valid),
        .out_data   (s1_data),
        .down_ready (s2_ready)
    );

    prr7_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_data    (s1_data),
        .up_ready   (s2_ready),
        .out_valid  (s2_valid),
        .out_data   (s2_data),
        .down_ready (s3_ready)
    );

    prr7_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_data    (s2_data),
        .up_ready   (s3_ready),
        .out_valid  (s3_valid),
        .out_data   (s3_data),
        .down_ready (s4_ready)
    );

    prr7_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid),
        .in_data    (s3_data),
        .up_ready   (s4_ready),
        .out_valid  (out_valid),
        .out_data   (res),
        .down_ready (!out_stall)
    );

    // Unpack the result
    assign rank_out   = res.rank;
    assign elem_out_0 = res.elem[0];
    assign elem_out_1 = res.elem[1];
    assign elem_out_2 = res.elem[2];
    assign elem_out_3 = res.elem[3];
    assign elem_out_4 = res.elem[4];
    assign elem_out_5 = res.elem[5];
    assign elem_out_6 = res.elem[6];
    assign bad_input  = res.bad;

endmodule

// File: sv/prr7_decode.sv
// ----------------------------------------------------------------------------
// prr7_decode
// Stage 1: input check, Lehmer digits in rank mode, first two factorial
// digits in unrank mode.
// ----------------------------------------------------------------------------
module prr7_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  prr7_pkg::req_t   in_data,
    output logic             up_ready,
    output logic             out_valid,
    output prr7_pkg::work_t  out_data,
    input  logic             down_ready
);
    import prr7_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    // Stage logic
    always_comb begin
        rank_t r1;
        rank_t r2;
        logic  bad;
        data_next    = '0;
        data_next.op = in_data.op;
        bad          = 1'b0;
        r1           = '0;
        r2           = '0;
        if (in_data.op == OP_RANK) begin
            // out-of-set value or duplicate
            for (int i = 0; i < NUM_ELEMS; i++) begin
                if (in_data.elem[i] == elem_t'(NUM_ELEMS)) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < NUM_ELEMS; j++) begin
                    if (in_data.elem[i] == in_data.elem[j]) begin
                        bad = 1'b1;
                    end
                end
            end
            // digit i: later elements smaller than element i
            for (int i = 0; i < NUM_ELEMS; i++) begin
                for (int j = i + 1; j < NUM_ELEMS; j++) begin
                    if (in_data.elem[j] < in_data.elem[i]) begin
                        data_next.digit[i] = data_next.digit[i] + elem_t'(1);
                    end
                end
            end
        end else begin
            bad                = (in_data.rank >= rank_t'(NUM_PERMS));
            data_next.digit[0] = div_digit(in_data.rank, FACT[6]);
            r1 = rank_t'(in_data.rank - rank_t'(rank_t'(data_next.digit[0]) * FACT[6]));
            data_next.digit[1] = div_digit(r1, FACT[5]);
            r2 = rank_t'(r1 - rank_t'(rank_t'(data_next.digit[1]) * FACT[5]));
        end
        data_next.bad = bad;
        data_next.rem = r2;
    end

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (up_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/prr7_digits.sv
// ----------------------------------------------------------------------------
// prr7_digits
// Stage 2: high part of the rank sum in rank mode, remaining factorial
// digits in unrank mode.
// ----------------------------------------------------------------------------
module prr7_digits (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  prr7_pkg::work_t  in_data,
    output logic             up_ready,
    output logic             out_valid,
    output prr7_pkg::work_t  out_data,
    input  logic             down_ready
);
    import prr7_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    // Stage logic
    always_comb begin
        rank_t r3;
        rank_t r4;
        data_next = in_data;
        r3        = '0;
        r4        = '0;
        if (in_data.op == OP_RANK) begin
            data_next.acc = rank_t'(rank_t'(rank_t'(in_data.digit[0]) * FACT[6])
                                  + rank_t'(rank_t'(in_data.digit[1]) * FACT[5])
                                  + rank_t'(rank_t'(in_data.digit[2]) * FACT[4]));
        end else begin
            data_next.digit[2] = div_digit(in_data.rem, FACT[4]);
            r3 = rank_t'(in_data.rem - rank_t'(rank_t'(data_next.digit[2]) * FACT[4]));
            data_next.digit[3] = div_digit(r3, FACT[3]);
            r4 = rank_t'(r3 - rank_t'(rank_t'(data_next.digit[3]) * FACT[3]));
            // r4 below 6: divide by 2 and 1
            data_next.digit[4] = elem_t'(r4[2:1]);
            data_next.digit[5] = elem_t'(r4[0]);
            data_next.digit[6] = '0;
        end
    end

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (up_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/prr7_merge.sv
// ----------------------------------------------------------------------------
// prr7_merge
// Stage 3: low part of the rank sum in rank mode, value selection for
// positions 0 to 2 in unrank mode.
// ----------------------------------------------------------------------------
module prr7_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  prr7_pkg::work_t  in_data,
    output logic             up_ready,
    output logic             out_valid,
    output prr7_pkg::work_t  out_data,
    input  logic             down_ready
);
    import prr7_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;

    // Stage logic
    always_comb begin
        data_next = in_data;
        if (in_data.op == OP_RANK) begin
            data_next.acc = rank_t'(in_data.acc
                                  + rank_t'(rank_t'(in_data.digit[3]) * FACT[3])
                                  + rank_t'(rank_t'(in_data.digit[4]) * FACT[2])
                                  + rank_t'(in_data.digit[5]));
        end else begin
            data_next.used = '0;
            for (int i = 0; i < 3; i++) begin
                data_next.pick[i] = pick_nth(data_next.used, in_data.digit[i]);
                data_next.used    = mark_used(data_next.used, data_next.pick[i]);
            end
        end
    end

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (up_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/prr7_finish.sv
// ----------------------------------------------------------------------------
// prr7_finish
// Stage 4: value selection for positions 3 to 6 in unrank mode, then
// result formatting with zeroing of unused and rejected fields.
// ----------------------------------------------------------------------------
module prr7_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  prr7_pkg::work_t  in_data,
    output logic             up_ready,
    output logic             out_valid,
    output prr7_pkg::res_t   out_data,
    input  logic             down_ready
);
    import prr7_pkg::*;

    logic  valid_reg;
    res_t  data_reg;
    res_t  data_next;

    // Stage logic
    always_comb begin
        mask_t       used;
        elem_t [6:0] pick;
        used = in_data.used;
        pick = in_data.pick;
        for (int i = 3; i < NUM_ELEMS - 1; i++) begin
            pick[i] = pick_nth(used, in_data.digit[i]);
            used    = mark_used(used, pick[i]);
        end
        // last position takes the only value left
        pick[6] = pick_nth(used, elem_t'(0));

        data_next     = '0;
        data_next.bad = in_data.bad;
        if (!in_data.bad) begin
            if (in_data.op == OP_RANK) begin
                data_next.rank = in_data.acc;
            end else begin
                data_next.elem = pick;
            end
        end
    end

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Valid bit
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (up_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: permutation_rank_unrank_7 testbench
// Drives ranking and unranking requests through the valid/stall input
// channel. A local predictor works out each conversion when its transfer is
// accepted, and a checker compares every output transfer with the oldest
// pending prediction. Both channels idle at random, with some stretches run
// back to back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prr7_pkg::*;

    // One conversion result as seen on the output ports
    typedef struct packed {
        rank_t       rank;
        elem_t [6:0] elem;
        logic        bad;
    } conv_t;

    // Weight of each position: (6 - position)!
    localparam int PLACE_WEIGHT [7] = '{720, 120, 24, 6, 2, 1, 1};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    elem_t       elem_in_0, elem_in_1, elem_in_2, elem_in_3;
    elem_t       elem_in_4, elem_in_5, elem_in_6;
    rank_t       rank_in;
    logic        out_valid;
    logic        out_stall;
    rank_t       rank_out;
    elem_t       elem_out_0, elem_out_1, elem_out_2, elem_out_3;
    elem_t       elem_out_4, elem_out_5, elem_out_6;
    logic        bad_input;

    conv_t       pending_conv[$];
    int          fail_count;
    bit          calm;

    permutation_rank_unrank_7 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_in_0  (elem_in_0),
        .elem_in_1  (elem_in_1),
        .elem_in_2  (elem_in_2),
        .elem_in_3  (elem_in_3),
        .elem_in_4  (elem_in_4),
        .elem_in_5  (elem_in_5),
        .elem_in_6  (elem_in_6),
        .rank_in    (rank_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rank_out   (rank_out),
        .elem_out_0 (elem_out_0),
        .elem_out_1 (elem_out_1),
        .elem_out_2 (elem_out_2),
        .elem_out_3 (elem_out_3),
        .elem_out_4 (elem_out_4),
        .elem_out_5 (elem_out_5),
        .elem_out_6 (elem_out_6),
        .bad_input  (bad_input)
    );

    // Clock: 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lehmer-code conversion in either direction
    function automatic conv_t convert_perm(input logic o, input elem_t [6:0] e,
                                           input rank_t r);
        conv_t      res;
        logic [7:0] taken;
        int         acc;
        int         rest;
        int         below;
        int         digit;
        int         seen;
        int         v;
        res   = '0;
        taken = '0;
        if (o == OP_RANK)
        begin
            acc = 0;
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                v = int'(e[i]);
                // out-of-set value or repeat: flag and zero everything
                if (v >= NUM_ELEMS || taken[v])
                begin
                    res     = '0;
                    res.bad = 1'b1;
                    return res;
                end
                below = 0;
                for (int w = 0; w < v; w++)
                    if (!taken[w])
                        below++;
                acc      += below * PLACE_WEIGHT[i];
                taken[v]  = 1'b1;
            end
            res.rank = rank_t'(acc);
        end
        else
        begin
            if (int'(r) >= NUM_PERMS)
            begin
                res.bad = 1'b1;
                return res;
            end
            rest = int'(r);
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                digit = rest / PLACE_WEIGHT[i];
                rest  = rest % PLACE_WEIGHT[i];
                seen  = 0;
                for (int c = 0; c < NUM_ELEMS; c++)
                begin
                    if (!taken[c])
                    begin
                        if (seen == digit)
                        begin
                            res.elem[i] = elem_t'(c);
                            taken[c]    = 1'b1;
                            break;
                        end
                        seen++;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic string conv_str(input conv_t c);
        return $sformatf("rank=%0d elem=%0d,%0d,%0d,%0d,%0d,%0d,%0d bad=%0d",
                         c.rank, c.elem[0], c.elem[1], c.elem[2], c.elem[3],
                         c.elem[4], c.elem[5], c.elem[6], c.bad);
    endfunction

    // Builds a position-ordered element vector, position 0 first
    function automatic elem_t [6:0] seq7(input int a, input int b, input int c,
                                         input int d, input int e, input int f,
                                         input int g);
        elem_t [6:0] p;
        p[0] = elem_t'(a);
        p[1] = elem_t'(b);
        p[2] = elem_t'(c);
        p[3] = elem_t'(d);
        p[4] = elem_t'(e);
        p[5] = elem_t'(f);
        p[6] = elem_t'(g);
        return p;
    endfunction

    function automatic elem_t [6:0] shuffled_perm();
        elem_t [6:0] p;
        elem_t       t;
        int          j;
        for (int i = 0; i < NUM_ELEMS; i++)
            p[i] = elem_t'(i);
        for (int i = NUM_ELEMS - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            t    = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        return p;
    endfunction

    function automatic elem_t [6:0] noise_elems();
        elem_t [6:0] p;
        for (int i = 0; i < NUM_ELEMS; i++)
            p[i] = elem_t'($urandom_range(0, 7));
        return p;
    endfunction

    // Idle cycles for one transfer; zero throughout a calm stretch
    function automatic int idle_cycles();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Sends one request and records its prediction on acceptance
    task automatic send_conv(input logic o, input elem_t [6:0] e, input rank_t r);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op        <= o;
        elem_in_0 <= e[0];
        elem_in_1 <= e[1];
        elem_in_2 <= e[2];
        elem_in_3 <= e[3];
        elem_in_4 <= e[4];
        elem_in_5 <= e[5];
        elem_in_6 <= e[6];
        rank_in   <= r;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_conv = {pending_conv, convert_perm(o, e, r)};
    endtask

    task automatic wait_drained();
        while (pending_conv.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, every op, duplicates, out-of-set elements, rank bounds
    task automatic test_directed();
        send_conv(OP_RANK,   seq7(0, 1, 2, 3, 4, 5, 6), 13'd0);
        send_conv(OP_RANK,   seq7(6, 5, 4, 3, 2, 1, 0), 13'd8191);
        send_conv(OP_RANK,   seq7(3, 0, 6, 1, 5, 2, 4), 13'd5040);
        send_conv(OP_RANK,   seq7(0, 0, 1, 2, 3, 4, 5), 13'd0);
        send_conv(OP_RANK,   seq7(0, 1, 2, 3, 4, 5, 5), 13'd0);
        send_conv(OP_RANK,   seq7(7, 1, 2, 3, 4, 5, 6), 13'd0);
        send_conv(OP_RANK,   seq7(0, 1, 2, 3, 4, 5, 7), 13'd0);
        send_conv(OP_RANK,   seq7(7, 7, 7, 7, 7, 7, 7), 13'd0);
        send_conv(OP_RANK,   seq7(0, 0, 0, 0, 0, 0, 0), 13'd0);
        send_conv(OP_RANK,   seq7(1, 0, 2, 3, 4, 5, 6), 13'd0);
        send_conv(OP_UNRANK, seq7(7, 7, 7, 7, 7, 7, 7), 13'd0);
        send_conv(OP_UNRANK, seq7(0, 0, 0, 0, 0, 0, 0), 13'd5039);
        send_conv(OP_UNRANK, seq7(6, 5, 4, 3, 2, 1, 0), 13'd5040);
        send_conv(OP_UNRANK, seq7(0, 1, 2, 3, 4, 5, 6), 13'd8191);
        send_conv(OP_UNRANK, seq7(0, 0, 0, 0, 0, 0, 0), 13'd4096);
        send_conv(OP_UNRANK, seq7(0, 0, 0, 0, 0, 0, 0), 13'd1);
        send_conv(OP_UNRANK, seq7(0, 0, 0, 0, 0, 0, 0), 13'd719);
        send_conv(OP_UNRANK, seq7(0, 0, 0, 0, 0, 0, 0), 13'd720);
    endtask

    // Ranking of shuffled permutations, a few corrupted
    task automatic test_rank_random(input int n);
        elem_t [6:0] p;
        for (int k = 0; k < n; k++)
        begin
            p = shuffled_perm();
            if ($urandom_range(0, 7) == 0)
                p[$urandom_range(0, 6)] = elem_t'($urandom_range(0, 7));
            send_conv(OP_RANK, p, rank_t'($urandom_range(0, 8191)));
        end
    endtask

    // Unranking, mostly in range, with junk on the element inputs
    task automatic test_unrank_random(input int n);
        rank_t r;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                r = rank_t'($urandom_range(NUM_PERMS, 8191));
            else
                r = rank_t'($urandom_range(0, NUM_PERMS - 1));
            send_conv(OP_UNRANK, noise_elems(), r);
        end
    endtask

    // Fully random fields in both modes
    task automatic test_noise(input int n);
        for (int k = 0; k < n; k++)
            send_conv(logic'($urandom_range(0, 1)), noise_elems(),
                      rank_t'($urandom_range(0, 8191)));
    endtask

    // Well-formed mixed traffic with no idling on either side
    task automatic test_back_to_back(input int n);
        calm = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_conv(OP_RANK, shuffled_perm(), rank_t'($urandom_range(0, 8191)));
            else
                send_conv(OP_UNRANK, noise_elems(),
                          rank_t'($urandom_range(0, NUM_PERMS - 1)));
        end
        calm = 1'b0;
    endtask

    // Sender holds off until the pipeline has fully emptied, then resumes
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        test_rank_random(20);
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        test_unrank_random(20);
    endtask

    // Receiver: random stall before each output transfer
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            n = idle_cycles();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid));
        end
    end

    // Checker: each output transfer against the oldest prediction
    always @(posedge clk)
    begin
        conv_t got;
        conv_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.rank = rank_out;
            got.elem = {elem_out_6, elem_out_5, elem_out_4, elem_out_3,
                        elem_out_2, elem_out_1, elem_out_0};
            got.bad  = bad_input;
            if (pending_conv.size() == 0)
                note_failure($sformatf("unexpected result %s", conv_str(got)));
            else
            begin
                want = pending_conv.pop_front();
                if (got.rank != want.rank || got.elem != want.elem || got.bad != want.bad)
                    note_failure($sformatf("expected %s, got %s",
                                           conv_str(want), conv_str(got)));
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL permutation_rank_unrank_7");
        $finish;
    end

    // Main sequence
    initial
    begin
        fail_count = 0;
        calm       = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_RANK;
        elem_in_0 <= '0;
        elem_in_1 <= '0;
        elem_in_2 <= '0;
        elem_in_3 <= '0;
        elem_in_4 <= '0;
        elem_in_5 <= '0;
        elem_in_6 <= '0;
        rank_in   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_rank_random(650);
        test_unrank_random(650);
        test_back_to_back(200);
        test_drain_pause();
        test_noise(450);

        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_conv.size() == 0)
            $display("PASS permutation_rank_unrank_7");
        else
        begin
            if (pending_conv.size() != 0)
                note_failure($sformatf("%0d results never arrived", pending_conv.size()));
            $display("FAIL permutation_rank_unrank_7");
        end
        $finish;
    end

endmodule
